// ===== hdl/sisl_pkg.sv =====
// Shared types, function codes and defaults for the interval series lookup unit.
package sisl_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int TIME_BITS_DEF   = 40;

    localparam logic [2:0] FUNC_CLEAR  = 3'd0;
    localparam logic [2:0] FUNC_APPEND = 3'd1;
    localparam logic [2:0] FUNC_COMMIT = 3'd2;
    localparam logic [2:0] FUNC_LOOKUP = 3'd3;
    localparam logic [2:0] FUNC_RANGE  = 3'd4;
    localparam logic [2:0] FUNC_GAP    = 3'd5;
    localparam logic [2:0] FUNC_BOUNDS = 3'd6;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_NONE  = 2'd2;

    localparam logic [3:0] GAP_HALVES_RESET = 4'd3;

endpackage

// ===== hdl/sisl_store.sv =====
// Sample store: one memory holding start and end of each interval, one read port.
module sisl_store #(
    parameter int MAX_SAMPLES = sisl_pkg::MAX_SAMPLES_DEF,
    parameter int TIME_BITS   = sisl_pkg::TIME_BITS_DEF,
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [TIME_BITS-1:0]   i_wstart,
    input  logic [TIME_BITS-1:0]   i_wend,
    input  logic [AW-1:0]          i_raddr,
    output logic [TIME_BITS-1:0]   o_rstart,
    output logic [TIME_BITS-1:0]   o_rend
);

    logic [2*TIME_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [2*TIME_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wstart, i_wend};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rstart = r_rdata[2*TIME_BITS-1:TIME_BITS];
    assign o_rend   = r_rdata[TIME_BITS-1:0];

endmodule

// ===== hdl/sisl_stride.sv =====
// Stride store: memory of start-to-start strides used by the median selection.
module sisl_stride #(
    parameter int MAX_SAMPLES = sisl_pkg::MAX_SAMPLES_DEF,
    parameter int TIME_BITS   = sisl_pkg::TIME_BITS_DEF,
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [TIME_BITS-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [TIME_BITS-1:0] o_rdata
);

    logic [TIME_BITS-1:0] r_mem [MAX_SAMPLES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/sorted_interval_series_lookup_unit.sv =====
// Top level of the sorted interval series lookup unit: sequencer and shared compare unit.
// An append walks the entries it shifts, lookup and range walk the table, and commit
// fetches each of the n-1 strides and inserts it into the stride memory, one shift at a
// time. One request at a time. The single read port of the sample memory is shared by
// every walk.
// Reset (synchronous, active low) empties the table, zeroes the step, sets gap_halves to 3.
module sorted_interval_series_lookup_unit #(
    parameter int MAX_SAMPLES = sisl_pkg::MAX_SAMPLES_DEF,
    parameter int TIME_BITS   = sisl_pkg::TIME_BITS_DEF,
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_func,
    input  logic [TIME_BITS-1:0] i_start_time,
    input  logic [TIME_BITS-1:0] i_end_time,
    input  logic [7:0]           i_query_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic                 o_hit,
    output logic [8:0]           o_first_index,
    output logic [8:0]           o_last_index,
    output logic                 o_gap_found,
    output logic [TIME_BITS-1:0] o_nominal_step,
    output logic [TIME_BITS-1:0] o_begin_time,
    output logic [TIME_BITS-1:0] o_end_time_out
);

    // Memory read data is registered: a state that reads uses the data in the state after it.
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_APRD  = 14'b00000000000010,  // read entry r_i-1 of the sample memory
        S_APCMP = 14'b00000000000100,  // compare it and shift or place the new sample
        S_LKRD  = 14'b00000000001000,
        S_LKCMP = 14'b00000000010000,
        S_RFRD  = 14'b00000000100000,
        S_RFCMP = 14'b00000001000000,
        S_RLCMP = 14'b00000010000000,
        S_CMRD  = 14'b00000100000000,  // copy strides out of the sample memory
        S_CMCMP = 14'b00001000000000,
        S_SORT  = 14'b00010000000000,  // insertion sort over the stride memory
        S_SOCMP = 14'b00100000000000,
        S_BNDS  = 14'b01000000000000,  // fetch the bound samples or the median stride
        S_OUT   = 14'b10000000000000
    } t_state;

    typedef struct packed {
        logic [1:0] status;
        logic       hit;
        logic [8:0] first;
        logic [8:0] last;
        logic       gap;
    } t_res;

    t_state r_state, n_state;
    t_res   r_res, n_res;

    logic [3:0]           r_gap_halves;
    logic [CW-1:0]        r_count, n_count;
    logic [TIME_BITS-1:0] r_step, n_step;
    logic [TIME_BITS-1:0] r_begin, n_begin, r_end, n_end;
    logic [2:0]           r_func;
    logic [TIME_BITS-1:0] r_t0, r_t1;
    logic [CW-1:0]        r_i, n_i, r_j, n_j;
    logic [TIME_BITS-1:0] r_prev, n_prev, r_key, n_key;
    logic                 r_phase, n_phase;
    logic                 r_bphase, n_bphase;

    logic                 s_we, t_we;
    logic [AW-1:0]        s_waddr, s_raddr, t_waddr, t_raddr;
    logic [TIME_BITS-1:0] s_wstart, s_wend, s_rstart, s_rend, t_wdata, t_rdata;

    // The shared compare unit: one magnitude compare of two time words.
    logic [TIME_BITS-1:0] cmp_a, cmp_b;
    logic                 cmp_gt;
    assign cmp_gt = cmp_a > cmp_b;

    // Exact gap threshold: stride*2 > step*g in TIME_BITS+5 bits.
    logic [TIME_BITS+4:0] gap_lhs, gap_rhs;

    sisl_store #(.MAX_SAMPLES(MAX_SAMPLES), .TIME_BITS(TIME_BITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wstart(s_wstart),
        .i_wend  (s_wend),
        .i_raddr (s_raddr),
        .o_rstart(s_rstart),
        .o_rend  (s_rend)
    );

    sisl_stride #(.MAX_SAMPLES(MAX_SAMPLES), .TIME_BITS(TIME_BITS)) u_stride (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status       = r_res.status;
    assign o_hit          = r_res.hit;
    assign o_first_index  = r_res.first;
    assign o_last_index   = r_res.last;
    assign o_gap_found    = r_res.gap;
    assign o_nominal_step = r_step;
    assign o_begin_time   = (r_count == '0) ? '0 : r_begin;
    assign o_end_time_out = (r_count == '0) ? '0 : r_end;

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        n_count  = r_count;
        n_step   = r_step;
        n_begin  = r_begin;
        n_end    = r_end;
        n_i      = r_i;
        n_j      = r_j;
        n_prev   = r_prev;
        n_key    = r_key;
        n_phase  = r_phase;
        n_bphase = r_bphase;
        s_we     = 1'b0;
        s_waddr  = r_i[AW-1:0];
        s_wstart = s_rstart;
        s_wend   = s_rend;
        s_raddr  = r_i[AW-1:0];
        t_we     = 1'b0;
        t_waddr  = r_j[AW-1:0];
        t_wdata  = r_key;
        t_raddr  = r_j[AW-1:0];
        cmp_a    = s_rstart;
        cmp_b    = r_t0;
        gap_lhs  = '0;
        gap_rhs  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res    = '0;
                    n_i      = '0;
                    // Every walk starts in its first phase.
                    n_phase  = 1'b0;
                    n_bphase = 1'b0;
                    case (i_func)
                        sisl_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                            n_step  = '0;
                            n_state = S_OUT;
                        end
                        sisl_pkg::FUNC_APPEND: begin
                            if (r_count == CW'(MAX_SAMPLES)) begin
                                n_res.status = sisl_pkg::STAT_FULL;
                                n_state = S_OUT;
                            end else begin
                                n_i = r_count;
                                n_state = S_APRD;
                            end
                        end
                        sisl_pkg::FUNC_COMMIT: begin
                            if (r_count < CW'(2)) begin
                                n_step  = '0;
                                n_state = S_OUT;
                            end else begin
                                n_phase = 1'b0;
                                n_state = S_CMRD;
                            end
                        end
                        sisl_pkg::FUNC_LOOKUP: n_state = S_LKRD;
                        sisl_pkg::FUNC_RANGE: begin
                            if (r_count == '0 || !(i_end_time > i_start_time)) begin
                                n_res.status = sisl_pkg::STAT_NONE;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_RFRD;
                            end
                        end
                        sisl_pkg::FUNC_GAP: begin
                            if ({1'b0, i_query_index} + 9'd1 >= 9'(r_count)
                                || r_step == '0) begin
                                n_res.status = sisl_pkg::STAT_NONE;
                                n_state = S_OUT;
                            end else begin
                                n_i     = CW'(i_query_index);
                                n_phase = 1'b0;
                                n_state = S_CMRD;
                            end
                        end
                        sisl_pkg::FUNC_BOUNDS: begin
                            if (r_count == '0) n_res.status = sisl_pkg::STAT_NONE;
                            n_state = S_OUT;
                        end
                        default: begin
                            n_res.status = sisl_pkg::STAT_NONE;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            // Append: r_i is the slot being filled; read r_i-1 and shift up if larger.
            S_APRD: begin
                if (r_i == '0) begin
                    s_we = 1'b1; s_waddr = '0;
                    s_wstart = r_t0; s_wend = r_t1;
                    n_count = r_count + CW'(1);
                    n_bphase = 1'b0; n_state = S_BNDS;
                end else begin
                    s_raddr = AW'(r_i - CW'(1));
                    n_state = S_APCMP;
                end
            end
            S_APCMP: begin
                cmp_a = s_rstart; cmp_b = r_t0;
                s_we = 1'b1; s_waddr = r_i[AW-1:0];
                if (cmp_gt) begin
                    n_i = r_i - CW'(1);
                    n_state = S_APRD;
                end else begin
                    s_wstart = r_t0; s_wend = r_t1;
                    n_count = r_count + CW'(1);
                    n_bphase = 1'b0; n_state = S_BNDS;
                end
            end
            // Lookup: scan while start <= t0; the entry before the stop is the candidate.
            // Once the scan stops, the second phase reads the candidate's end.
            S_LKRD: begin
                n_phase = r_phase || (r_i == r_count);
                n_state = S_LKCMP;
                s_raddr = (r_i == r_count || r_phase) ? AW'(r_i - CW'(1)) : r_i[AW-1:0];
            end
            S_LKCMP: begin
                if (r_phase) begin
                    if (r_i == '0 || !(s_rend > r_t0)) begin
                        n_res.status = sisl_pkg::STAT_NONE;
                    end else begin
                        n_res.hit = 1'b1;
                        n_res.first = 9'(r_i - CW'(1));
                    end
                    n_state = S_OUT;
                end else begin
                    cmp_a = s_rstart; cmp_b = r_t0;
                    if (!cmp_gt) begin
                        n_i = r_i + CW'(1);
                    end else begin
                        n_phase = 1'b1;
                    end
                    n_state = S_LKRD;
                end
            end
            // Range: first skips ends at or before t0, then last advances on start < t1.
            S_RFRD: begin
                n_state = (r_i == r_count) ? S_OUT : (r_phase ? S_RLCMP : S_RFCMP);
                if (r_i == r_count) begin
                    if (!r_phase) n_res.first = 9'(r_i);
                    n_res.last = 9'(r_i);
                end
            end
            S_RFCMP: begin
                cmp_a = s_rend; cmp_b = r_t0;
                if (cmp_gt) begin
                    n_res.first = 9'(r_i);
                    n_phase = 1'b1;
                end else begin
                    n_i = r_i + CW'(1);
                end
                n_state = S_RFRD;
            end
            S_RLCMP: begin
                cmp_a = r_t1; cmp_b = s_rstart;
                if (cmp_gt) begin
                    n_i = r_i + CW'(1);
                    n_state = S_RFRD;
                end else begin
                    n_res.last = 9'(r_i);
                    n_state = S_OUT;
                end
            end
            // Stride fetch, shared by commit and gap: read entry r_i then r_i+1.
            S_CMRD: begin
                s_raddr = r_phase ? AW'(r_i + CW'(1)) : r_i[AW-1:0];
                n_state = S_CMCMP;
            end
            S_CMCMP: begin
                if (!r_phase) begin
                    n_prev  = s_rstart;
                    n_phase = 1'b1;
                    n_state = S_CMRD;
                end else begin
                    n_key = s_rstart - r_prev;
                    n_phase = 1'b0;
                    if (r_func == sisl_pkg::FUNC_GAP) begin
                        gap_lhs = {(TIME_BITS+5)'(s_rstart - r_prev)} << 1;
                        gap_rhs = (TIME_BITS+5)'(r_step) * (TIME_BITS+5)'(r_gap_halves);
                        n_res.gap = gap_lhs > gap_rhs;
                        n_state = S_OUT;
                    end else begin
                        n_j = r_i;
                        n_state = S_SORT;
                    end
                end
            end
            // Insertion of key at slot r_j: read r_j-1, shift up while greater.
            S_SORT: begin
                if (r_j == '0) begin
                    t_we = 1'b1; t_waddr = '0; t_wdata = r_key;
                    n_state = S_SOCMP; n_phase = 1'b1;
                end else begin
                    t_raddr = AW'(r_j - CW'(1));
                    n_state = S_SOCMP; n_phase = 1'b0;
                end
            end
            S_SOCMP: begin
                cmp_a = t_rdata; cmp_b = r_key;
                if (!r_phase && cmp_gt) begin
                    t_we = 1'b1; t_waddr = r_j[AW-1:0]; t_wdata = t_rdata;
                    n_j = r_j - CW'(1);
                    n_state = S_SORT;
                end else begin
                    if (!r_phase) begin
                        t_we = 1'b1; t_waddr = r_j[AW-1:0]; t_wdata = r_key;
                    end
                    n_phase = 1'b0;
                    if (r_i + CW'(2) == r_count) begin
                        // All strides sorted: fetch the middle one, the upper of the two for an even count.
                        n_j = CW'((r_count - CW'(1)) >> 1);
                        n_bphase = 1'b1;
                        n_state = S_BNDS;
                    end else begin
                        n_i = r_i + CW'(1);
                        n_state = S_CMRD;
                    end
                end
            end
            S_BNDS: begin
                // After an append, read entry 0 and then the last entry.
                // After a commit, read the median slot of the stride memory.
                if (r_func == sisl_pkg::FUNC_COMMIT) begin
                    t_raddr = r_j[AW-1:0];
                    if (!r_bphase) begin
                        n_step = t_rdata;
                        n_state = S_OUT;
                    end
                    n_bphase = 1'b0;
                end else begin
                    s_raddr = r_bphase ? AW'(r_count - CW'(1)) : '0;
                    if (r_phase) begin
                        n_end = s_rend;
                        n_phase = 1'b0;
                        n_state = S_OUT;
                    end else if (r_bphase) begin
                        n_begin = s_rstart;
                        n_phase = 1'b1;
                    end
                    n_bphase = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_step       <= '0;
            r_gap_halves <= sisl_pkg::GAP_HALVES_RESET;
            r_phase      <= 1'b0;
            r_bphase     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_phase  <= n_phase;
            r_bphase <= n_bphase;
            if (i_cfg_we) r_gap_halves <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_begin <= n_begin;
        r_end   <= n_end;
        r_i     <= n_i;
        r_j     <= n_j;
        r_prev  <= n_prev;
        r_key   <= n_key;
        if (r_state == S_IDLE && i_valid) begin
            r_func <= i_func;
            r_t0   <= i_start_time;
            r_t1   <= i_end_time;
        end
    end

    // The table never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count beyond table depth");

    // A result is offered only after a request was taken or while one was in work.
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid || r_state != S_IDLE))
        else $error("result without a request");

    // An append that is not dropped leaves the table non-empty.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) != S_OUT && r_func == sisl_pkg::FUNC_APPEND
         && r_res.status == sisl_pkg::STAT_OK) |-> r_count != '0)
        else $error("append left the table empty");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sorted interval series lookup unit.
`timescale 1ns / 1ps

module testbench;

    localparam int TW = sisl_pkg::TIME_BITS_DEF;
    localparam int DEPTH = sisl_pkg::MAX_SAMPLES_DEF;
    // Longest stretch without any handshake. A commit on a full table sorts about
    // 256 strides with a single read port, so the limit must cover that whole sort.
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]    func;
        logic [TW-1:0] t0;
        logic [TW-1:0] t1;
        logic [7:0]    qi;
    } request_t;

    typedef struct packed {
        logic [1:0]    status;
        logic          hit;
        logic [8:0]    first;
        logic [8:0]    last;
        logic          gap;
        logic [TW-1:0] step;
        logic [TW-1:0] t_begin;
        logic [TW-1:0] t_finish;
    } outcome_t;

    // Directed row: the expectation is typed in only when the flag is set.
    typedef struct {
        request_t rq;
        bit       typed;
        outcome_t want;
    } row_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [3:0]    i_cfg_wdata = '0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [2:0]    i_func = '0;
    logic [TW-1:0] i_start_time = '0;
    logic [TW-1:0] i_end_time = '0;
    logic [7:0]    i_query_index = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [1:0]    o_status;
    logic          o_hit;
    logic [8:0]    o_first_index;
    logic [8:0]    o_last_index;
    logic          o_gap_found;
    logic [TW-1:0] o_nominal_step;
    logic [TW-1:0] o_begin_time;
    logic [TW-1:0] o_end_time_out;

    sorted_interval_series_lookup_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the series table, the committed step and the gap threshold.
    logic [TW-1:0] starts [DEPTH];
    logic [TW-1:0] ends [DEPTH];
    int            n_samples = 0;
    logic [TW-1:0] step_med = '0;
    logic [3:0]    thr_halves = sisl_pkg::GAP_HALVES_RESET;

    outcome_t pending_results[$];
    int       mismatches = 0;
    int       watchdog = 0;
    bit       quiet = 1'b0;
    int       stall_left = 0;

    function automatic logic [TW-1:0] r40();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[TW-1:0];
    endfunction

    // Applies one request to the shadow state and returns the result it must produce.
    function automatic outcome_t series_step(request_t rq);
        outcome_t      o;
        int            pos, after, f, l, m;
        logic [TW-1:0] strides[$];
        logic [TW-1:0] stride;
        logic [47:0]   lhs, rhs;
        o = '0;
        case (rq.func)
            sisl_pkg::FUNC_CLEAR: begin
                n_samples = 0;
                step_med = '0;
            end
            sisl_pkg::FUNC_APPEND: begin
                if (n_samples >= DEPTH) begin
                    o.status = sisl_pkg::STAT_FULL;
                end else begin
                    // Equal starts keep arrival order: the new one goes after them.
                    pos = n_samples;
                    while (pos > 0 && starts[pos-1] > rq.t0) begin
                        starts[pos] = starts[pos-1];
                        ends[pos] = ends[pos-1];
                        pos--;
                    end
                    starts[pos] = rq.t0;
                    ends[pos] = rq.t1;
                    n_samples++;
                end
            end
            sisl_pkg::FUNC_COMMIT: begin
                if (n_samples < 2) begin
                    step_med = '0;
                end else begin
                    m = n_samples - 1;
                    for (int i = 0; i < m; i++)
                        strides.insert(strides.size(), starts[i+1] - starts[i]);
                    strides.sort();
                    step_med = strides[m/2];
                end
            end
            sisl_pkg::FUNC_LOOKUP: begin
                after = 0;
                while (after < n_samples && starts[after] <= rq.t0) after++;
                if (after == 0 || !(rq.t0 < ends[after-1])) begin
                    o.status = sisl_pkg::STAT_NONE;
                end else begin
                    o.hit = 1'b1;
                    o.first = 9'(after - 1);
                end
            end
            sisl_pkg::FUNC_RANGE: begin
                if (n_samples == 0 || rq.t1 <= rq.t0) begin
                    o.status = sisl_pkg::STAT_NONE;
                end else begin
                    f = 0;
                    while (f < n_samples && ends[f] <= rq.t0) f++;
                    l = f;
                    while (l < n_samples && starts[l] < rq.t1) l++;
                    o.first = 9'(f);
                    o.last = 9'(l);
                end
            end
            sisl_pkg::FUNC_GAP: begin
                if (int'(rq.qi) + 1 >= n_samples || step_med == '0) begin
                    o.status = sisl_pkg::STAT_NONE;
                end else begin
                    // stride > step * halves / 2, done exactly as stride * 2 > step * halves.
                    stride = starts[rq.qi+1] - starts[rq.qi];
                    lhs = {7'd0, stride, 1'b0};
                    rhs = 48'(step_med) * 48'(thr_halves);
                    o.gap = (lhs > rhs);
                end
            end
            sisl_pkg::FUNC_BOUNDS: begin
                if (n_samples == 0) o.status = sisl_pkg::STAT_NONE;
            end
            default: o.status = sisl_pkg::STAT_NONE;
        endcase
        o.step = step_med;
        o.t_begin = (n_samples == 0) ? '0 : starts[0];
        o.t_finish = (n_samples == 0) ? '0 : ends[n_samples-1];
        return o;
    endfunction

    // Drives one request at a falling edge and returns at the edge that accepts it.
    // The expectation is queued only then, so the shadow state follows the block.
    task automatic issue(request_t rq, bit typed = 1'b0, outcome_t want = '0);
        outcome_t predicted;
        int       idle;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            idle = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= rq.func;
        i_start_time <= rq.t0;
        i_end_time <= rq.t1;
        i_query_index <= rq.qi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = series_step(rq);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic quick(logic [2:0] func, logic [TW-1:0] t0 = '0, logic [TW-1:0] t1 = '0,
                         logic [7:0] qi = '0);
        issue('{func: func, t0: t0, t1: t1, qi: qi});
    endtask

    // The threshold register is only written once every result is back.
    task automatic write_halves(logic [3:0] value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thr_halves = value;
    endtask

    // One episode: empty the table, fill it with a short series, usually commit,
    // then ask questions about it. The big variant overfills the whole table.
    task automatic episode(bit big, inout int sent);
        int            k, idx, nq, kind;
        logic [TW-1:0] t, pitch, t0, t1;
        bit            ordered;
        bit            do_commit;
        quick(sisl_pkg::FUNC_CLEAR);
        k = big ? DEPTH + 4 : $urandom_range(0, 10);
        ordered = big || ($urandom_range(0, 3) != 0);
        t = ($urandom_range(0, 2) == 0) ? r40() : TW'($urandom_range(0, 1000));
        pitch = TW'($urandom_range(1, 60));
        for (int i = 0; i < k; i++) begin
            if (ordered) begin
                t = t + pitch;
                // Now and then a longer hole, which the gap query should flag.
                if ($urandom_range(0, 5) == 0) t = t + pitch * TW'($urandom_range(1, 4));
                t0 = t;
            end else begin
                t0 = t + TW'($urandom_range(0, 300));
            end
            t1 = ($urandom_range(0, 9) == 0) ? r40()
                                             : t0 + TW'($urandom_range(0, 32'(2 * pitch)));
            quick(sisl_pkg::FUNC_APPEND, t0, t1);
        end
        do_commit = ($urandom_range(0, 9) != 0);
        if (do_commit) quick(sisl_pkg::FUNC_COMMIT);
        nq = big ? 16 : $urandom_range(4, 12);
        for (int q = 0; q < nq; q++) begin
            kind = $urandom_range(0, 9);
            idx = (n_samples > 0) ? $urandom_range(0, n_samples - 1) : 0;
            t0 = (n_samples > 0) ? starts[idx] + TW'($urandom_range(0, 40)) - TW'(8) : r40();
            case (kind)
                0, 1, 2: quick(sisl_pkg::FUNC_LOOKUP, t0, r40());
                3, 4: begin
                    t1 = ($urandom_range(0, 5) == 0) ? t0 - TW'($urandom_range(0, 3))
                                                     : t0 + TW'($urandom_range(1, 200));
                    if ($urandom_range(0, 7) == 0) begin
                        t0 = r40();
                        t1 = r40();
                    end
                    quick(sisl_pkg::FUNC_RANGE, t0, t1);
                end
                5, 6: begin
                    if (n_samples > 0 && $urandom_range(0, 3) != 0)
                        quick(sisl_pkg::FUNC_GAP, r40(), r40(),
                              8'($urandom_range(0, n_samples - 1)));
                    else
                        quick(sisl_pkg::FUNC_GAP, r40(), r40(), 8'($urandom_range(0, 255)));
                end
                7: quick(sisl_pkg::FUNC_BOUNDS, r40(), r40(), 8'($urandom_range(0, 255)));
                default: quick(3'($urandom_range(0, 7)), r40(), r40(), 8'($urandom_range(0, 255)));
            endcase
        end
        if (big) begin
            quick(sisl_pkg::FUNC_GAP, '0, '0, 8'd254);
            quick(sisl_pkg::FUNC_GAP, '0, '0, 8'd255);
        end
        sent += 1 + k + int'(do_commit) + nq + (big ? 2 : 0);
    endtask

    // Responder stall: random bursts, none in the quiet tail.
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: every accepted result must match the oldest expectation.
    always @(posedge i_clk) begin
        outcome_t got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_hit, o_first_index, o_last_index, o_gap_found,
                    o_nominal_step, o_begin_time, o_end_time_out};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request or result.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    localparam logic [TW-1:0] TMAX = '1;

    initial begin
        row_t       rows[$];
        outcome_t   none, okz;
        logic [3:0] halves_plan[8];
        int         sent;
        none = '0;
        none.status = sisl_pkg::STAT_NONE;
        okz = '0;
        // Empty table: every question has no answer, an unused code does nothing,
        // and a commit of nothing yields a zero step.
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_BOUNDS, '0, '0, 8'd0}, 1'b1, none});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_LOOKUP, TMAX, TMAX, 8'd255}, 1'b1, none});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_RANGE, '0, TMAX, 8'd0}, 1'b1, none});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_GAP, '0, '0, 8'd0}, 1'b1, none});
        rows.insert(rows.size(), '{'{3'd7, TMAX, TMAX, 8'd255}, 1'b1, none});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_COMMIT, '0, '0, 8'd0}, 1'b1, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_APPEND, '0, TMAX, 8'd0}, 1'b1,
                    '{sisl_pkg::STAT_OK, 1'b0, 9'd0, 9'd0, 1'b0, '0, '0, TMAX}});
        // Extremes, an insertion into the middle and a duplicate start.
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_APPEND, TMAX, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_APPEND, 40'd100, 40'd200, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_APPEND, 40'd100, 40'd150, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_GAP, '0, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_COMMIT, '0, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_LOOKUP, '0, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_LOOKUP, TMAX, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_LOOKUP, 40'd150, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_RANGE, '0, TMAX, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_RANGE, 40'd50, 40'd50, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_RANGE, 40'd160, 40'd170, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_GAP, '0, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_GAP, '0, '0, 8'd2}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_GAP, '0, '0, 8'd255}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_BOUNDS, '0, '0, 8'd0}, 1'b0, okz});
        rows.insert(rows.size(), '{'{sisl_pkg::FUNC_CLEAR, TMAX, TMAX, 8'd255}, 1'b1, okz});

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) issue(rows[r].rq, rows[r].typed, rows[r].want);

        // Threshold settings per phase: reset value, 2 and 15, the two smallest values 0 and 1,
        // two random ones, then the reset value again. The last phase is quiet.
        halves_plan = '{sisl_pkg::GAP_HALVES_RESET, 4'd2, 4'd15, 4'd0, 4'd1,
                        4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 4'd3};
        for (int p = 0; p < 8; p++) begin
            if (p > 0) write_halves(halves_plan[p]);
            quiet = (p == 7);
            sent = 0;
            if (p == 2) episode(1'b1, sent);
            sent = 0;
            while (sent < 12) episode(1'b0, sent);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
